[src/bfiq_pkg.sv]
// Shared constants, hash tables and structs for the Bloom filter block.
// Depends on nothing; every other file refers to it by scoped names.
package bfiq_pkg;

    localparam int KEY_W      = 31;
    localparam int FUNC_W     = 1;
    localparam int OUTCOME_W  = 2;
    localparam int COUNT_W    = 13;
    localparam int SIZE_W     = 13;
    localparam int HCNT_W     = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_REJECTED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_ABSENT   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_PRESENT  = 2'd3;

    localparam int DEF_MAX_BITS   = 4096;
    localparam int MAX_HASHES     = 12;
    localparam int HASH_NUM       = 12;
    localparam int HIDX_W         = 4;
    localparam int DEF_USED_BITS  = 4096;
    localparam int DEF_HASH_COUNT = 4;

    localparam int SUM_W      = 54;
    localparam int MOD_BITS   = 8;
    localparam int MOD_STAGES = (SUM_W + MOD_BITS - 1) / MOD_BITS;
    localparam int DIV_W      = MOD_STAGES * MOD_BITS;

    localparam int ROW_W      = 8;
    localparam int ROW_BIT_W  = 3;

    localparam logic [4:0] FIRST_SHIFT [HASH_NUM] =
        '{5'd6, 5'd5, 5'd4, 5'd13, 5'd7, 5'd11, 5'd8, 5'd21, 5'd23, 5'd30, 5'd26, 5'd31};
    localparam logic FIRST_LEFT [HASH_NUM] =
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam logic [4:0] SECOND_SHIFT [HASH_NUM] =
        '{5'd16, 5'd7, 5'd17, 5'd14, 5'd18, 5'd20, 5'd19, 5'd15, 5'd13, 5'd2, 5'd22, 5'd5};

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [HCNT_W-1:0] nh;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [HIDX_W-1:0] hidx;
    } hreq_t;

    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] idx;
    } probe_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } presult_t;

endpackage

[src/bfiq_channels.sv]
// Valid/ready channel interfaces for request items and result items.
// Depends on bfiq_pkg for the payload widths.
interface bfiq_req_if;
    logic                        valid;
    logic                        ready;
    logic [bfiq_pkg::FUNC_W-1:0] func;
    logic [bfiq_pkg::KEY_W-1:0]  key;

    modport source (output valid, func, key, input ready);
    modport sink   (input valid, func, key, output ready);
endinterface

interface bfiq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bfiq_pkg::OUTCOME_W-1:0] outcome;
    logic [bfiq_pkg::COUNT_W-1:0]   stored_count;

    modport source (output valid, outcome, stored_count, input ready);
    modport sink   (input valid, outcome, stored_count, output ready);
endinterface

[src/bloom_filter_insert_query.sv]
// Bloom filter top level: item control, count, result register and the three units.
// Depends on bfiq_pkg, the channel interfaces, bfiq_cfg, bfiq_hash and bfiq_store.
// A probed item's result passes through the hash, modulo and store-read pipeline; a rejected
// insert's result is loaded straight from the DONE state. One item at a time: the next item is
// taken only after the result of the last one has been loaded into the output register.
// Reset clears the store one byte row per cycle, with the input held off until it is done.
module bloom_filter_insert_query #(
    parameter int MAX_BITS = bfiq_pkg::DEF_MAX_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfiq_pkg::ADDR_W-1:0] paddr,
    input  logic [bfiq_pkg::DATA_W-1:0] pwdata,
    output logic [bfiq_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    bfiq_req_if.sink                    in_ch,
    bfiq_rsp_if.source                  out_ch
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam int CNT_W  = bfiq_pkg::COUNT_W + 1;
    localparam int PROD_W = CNT_W + bfiq_pkg::HCNT_W;

    bfiq_pkg::cfg_t     cfg;
    bfiq_pkg::hreq_t    hreq;
    bfiq_pkg::probe_t   probe;
    bfiq_pkg::presult_t presult;
    logic               clearing;

    logic [1:0]                     state_reg, state_next;
    logic [bfiq_pkg::HIDX_W-1:0]    hidx_reg, hidx_next;
    logic [bfiq_pkg::HCNT_W-1:0]    done_cnt_reg, done_cnt_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           func_reg;
    logic [bfiq_pkg::KEY_W-1:0]     key_reg;
    logic                           hit_reg;
    logic [bfiq_pkg::OUTCOME_W-1:0] res_outcome_reg;
    logic [bfiq_pkg::COUNT_W-1:0]   res_count_reg;
    logic [bfiq_pkg::OUTCOME_W-1:0] out_outcome_reg;
    logic [bfiq_pkg::COUNT_W-1:0]   out_count_reg;

    logic                           in_fire;
    logic                           out_free;
    logic                           out_load;
    logic [PROD_W-1:0]              load_prod;
    logic                           reject;
    logic [CNT_W-1:0]               count_inc;
    logic [bfiq_pkg::OUTCOME_W-1:0] final_outcome;

    bfiq_cfg #(
        .MAX_BITS (MAX_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bfiq_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .key   (key_reg),
        .size  (cfg.size),
        .probe (probe)
    );

    bfiq_store #(
        .MAX_BITS (MAX_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .probe    (probe),
        .set_bits (func_reg == bfiq_pkg::FUNC_INSERT),
        .result   (presult),
        .clearing (clearing)
    );

    assign in_ch.ready = (state_reg == ST_IDLE) && !clearing;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // A count above size/hashes is the same test as count*hashes above size.
    assign load_prod = PROD_W'(count_reg) * PROD_W'(cfg.nh);
    assign reject    = (in_ch.func == bfiq_pkg::FUNC_INSERT) && (load_prod > PROD_W'(cfg.size));
    assign count_inc = count_reg + 1'b1;

    assign hreq.valid = (state_reg == ST_ISSUE);
    assign hreq.hidx  = hidx_reg;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    assign final_outcome = (func_reg == bfiq_pkg::FUNC_QUERY)
                         ? (hit_reg ? bfiq_pkg::OUT_PRESENT : bfiq_pkg::OUT_ABSENT)
                         : res_outcome_reg;

    always_comb
    begin
        state_next     = state_reg;
        hidx_next      = hidx_reg;
        done_cnt_next  = done_cnt_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;

        if (presult.valid)
            done_cnt_next = done_cnt_reg + 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    hidx_next     = '0;
                    done_cnt_next = '0;
                    if (reject)
                        state_next = ST_DONE;
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (in_ch.func == bfiq_pkg::FUNC_INSERT)
                            count_next = count_inc;
                    end
                end
            end
            ST_ISSUE:
            begin
                hidx_next = hidx_reg + 1'b1;
                if (hidx_reg == bfiq_pkg::HIDX_W'(cfg.nh - 1'b1))
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (done_cnt_reg == cfg.nh)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hidx_reg      <= '0;
            done_cnt_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hidx_reg      <= hidx_next;
            done_cnt_reg  <= done_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= in_ch.func;
            key_reg  <= in_ch.key;
            hit_reg  <= 1'b1;
            if (reject)
            begin
                res_outcome_reg <= bfiq_pkg::OUT_REJECTED;
                res_count_reg   <= count_reg[bfiq_pkg::COUNT_W-1:0];
            end
            else if (in_ch.func == bfiq_pkg::FUNC_INSERT)
            begin
                res_outcome_reg <= bfiq_pkg::OUT_INSERTED;
                res_count_reg   <= count_inc[bfiq_pkg::COUNT_W-1:0];
            end
            else
            begin
                res_outcome_reg <= bfiq_pkg::OUT_ABSENT;
                res_count_reg   <= count_reg[bfiq_pkg::COUNT_W-1:0];
            end
        end
        else if (presult.valid)
            hit_reg <= hit_reg && presult.hit;

        if (out_load)
        begin
            out_outcome_reg <= final_outcome;
            out_count_reg   <= res_count_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.outcome      = out_outcome_reg;
    assign out_ch.stored_count = out_count_reg;

endmodule

[src/bfiq_cfg.sv]
// APB-style register file for the used size and the hash count.
// Depends on bfiq_pkg; delivers the clamped settings as a cfg_t.
module bfiq_cfg #(
    parameter int MAX_BITS = bfiq_pkg::DEF_MAX_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfiq_pkg::ADDR_W-1:0] paddr,
    input  logic [bfiq_pkg::DATA_W-1:0] pwdata,
    output logic [bfiq_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output bfiq_pkg::cfg_t              cfg
);

    localparam logic REG_USED_BITS  = 1'b0;
    localparam logic REG_HASH_COUNT = 1'b1;
    localparam int   SIZE_LIM  = (1 << bfiq_pkg::SIZE_W) - 1;
    localparam int   SIZE_CAP  = (MAX_BITS < SIZE_LIM) ? MAX_BITS : SIZE_LIM;

    logic [bfiq_pkg::SIZE_W-1:0] used_bits_reg;
    logic [bfiq_pkg::HCNT_W-1:0] hash_count_reg;
    logic [bfiq_pkg::ADDR_W-1:0] word_addr;
    logic                        reg_sel;
    logic                        wr_en;

    assign pready    = 1'b1;
    assign word_addr = paddr >> 2;
    assign reg_sel   = word_addr[0];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_bits_reg  <= bfiq_pkg::SIZE_W'(bfiq_pkg::DEF_USED_BITS);
            hash_count_reg <= bfiq_pkg::HCNT_W'(bfiq_pkg::DEF_HASH_COUNT);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_USED_BITS:  used_bits_reg  <= pwdata[bfiq_pkg::SIZE_W-1:0];
                REG_HASH_COUNT: hash_count_reg <= pwdata[bfiq_pkg::HCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_USED_BITS:  prdata = bfiq_pkg::DATA_W'(used_bits_reg);
            REG_HASH_COUNT: prdata = bfiq_pkg::DATA_W'(hash_count_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        if (used_bits_reg == '0)
            cfg.size = bfiq_pkg::SIZE_W'(1);
        else if (used_bits_reg > bfiq_pkg::SIZE_W'(SIZE_CAP))
            cfg.size = bfiq_pkg::SIZE_W'(SIZE_CAP);
        else
            cfg.size = used_bits_reg;

        if (hash_count_reg == '0)
            cfg.nh = bfiq_pkg::HCNT_W'(1);
        else if (hash_count_reg > bfiq_pkg::HCNT_W'(bfiq_pkg::MAX_HASHES))
            cfg.nh = bfiq_pkg::HCNT_W'(bfiq_pkg::MAX_HASHES);
        else
            cfg.nh = hash_count_reg;
    end

endmodule

[src/bfiq_hash.sv]
// Hash term generation and a pipelined modulo unit, one probe index per cycle.
// Depends on bfiq_pkg for the shift tables and the probe structs.
module bfiq_hash (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bfiq_pkg::hreq_t            req,
    input  logic [bfiq_pkg::KEY_W-1:0] key,
    input  logic [bfiq_pkg::SIZE_W-1:0] size,
    output bfiq_pkg::probe_t           probe
);

    localparam int SW = bfiq_pkg::SIZE_W;
    localparam int NS = bfiq_pkg::MOD_STAGES;
    localparam int DW = bfiq_pkg::DIV_W;
    localparam int MB = bfiq_pkg::MOD_BITS;

    function automatic logic [SW-1:0] mod_step(input logic [SW-1:0] rem,
                                               input logic [MB-1:0] bits,
                                               input logic [SW-1:0] modulus);
        logic [SW:0]   t;
        logic [SW-1:0] r;
        r = rem;
        for (int b = MB - 1; b >= 0; b--)
        begin
            t = {r, bits[b]};
            if (t >= {1'b0, modulus})
                t = t - {1'b0, modulus};
            r = t[SW-1:0];
        end
        return r;
    endfunction

    logic [bfiq_pkg::SUM_W-1:0] key_ext;
    logic [bfiq_pkg::SUM_W-1:0] first_term;
    logic [bfiq_pkg::SUM_W-1:0] second_term;
    logic [bfiq_pkg::SUM_W-1:0] p0_next;
    logic [bfiq_pkg::SUM_W-1:0] p1_next;

    logic                       t_valid_reg;
    logic [bfiq_pkg::SUM_W-1:0] p0_reg;
    logic [bfiq_pkg::SUM_W-1:0] p1_reg;
    logic                       s_valid_reg;
    logic [DW-1:0]              sum_reg;
    logic                       m_valid_reg [NS];
    logic [SW-1:0]              m_rem_reg   [NS];
    logic [DW-1:0]              m_div_reg   [NS-1];

    always_comb
    begin
        key_ext = bfiq_pkg::SUM_W'(key);
        if (bfiq_pkg::FIRST_LEFT[req.hidx])
            first_term = key_ext << bfiq_pkg::FIRST_SHIFT[req.hidx];
        else
            first_term = key_ext >> bfiq_pkg::FIRST_SHIFT[req.hidx];
        second_term = key_ext << bfiq_pkg::SECOND_SHIFT[req.hidx];
        p0_next     = key_ext + first_term;
        p1_next     = second_term + (key_ext >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            for (int k = 0; k < NS; k++)
                m_valid_reg[k] <= 1'b0;
        end
        else
        begin
            t_valid_reg    <= req.valid;
            s_valid_reg    <= t_valid_reg;
            m_valid_reg[0] <= s_valid_reg;
            for (int k = 1; k < NS; k++)
                m_valid_reg[k] <= m_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        sum_reg      <= DW'(p0_reg + p1_reg);
        m_rem_reg[0] <= mod_step('0, sum_reg[DW-1 -: MB], size);
        m_div_reg[0] <= sum_reg << MB;
        for (int k = 1; k < NS; k++)
            m_rem_reg[k] <= mod_step(m_rem_reg[k-1], m_div_reg[k-1][DW-1 -: MB], size);
        for (int k = 1; k < NS - 1; k++)
            m_div_reg[k] <= m_div_reg[k-1] << MB;
    end

    assign probe.valid = m_valid_reg[NS-1];
    assign probe.idx   = m_rem_reg[NS-1];

endmodule

[src/bfiq_store.sv]
// Filter bit store: a byte-wide synchronous memory with read-modify-write
// of probed rows, one-back forwarding and a clearing pass after reset.
// Depends on bfiq_pkg for the probe structs and row geometry.
module bfiq_store #(
    parameter int MAX_BITS = bfiq_pkg::DEF_MAX_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bfiq_pkg::probe_t   probe,
    input  logic               set_bits,
    output bfiq_pkg::presult_t result,
    output logic               clearing
);

    localparam int RW    = bfiq_pkg::ROW_W;
    localparam int RB    = bfiq_pkg::ROW_BIT_W;
    localparam int ROWS  = (MAX_BITS + RW - 1) / RW;
    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int EXT_W = (bfiq_pkg::SIZE_W > RAW + RB) ? bfiq_pkg::SIZE_W : RAW + RB;

    logic [RW-1:0]    mem [ROWS];

    logic [EXT_W-1:0] idx_ext;
    logic [RAW-1:0]   rd_row;
    logic [RB-1:0]    rd_bit;

    logic             clr_busy_reg;
    logic [RAW-1:0]   clr_row_reg;
    logic             s1_valid_reg;
    logic [RAW-1:0]   s1_row_reg;
    logic [RB-1:0]    s1_bit_reg;
    logic             s1_set_reg;
    logic [RW-1:0]    rdata_reg;
    logic             wb_valid_reg;
    logic [RAW-1:0]   wb_row_reg;
    logic [RW-1:0]    wb_data_reg;

    logic [RW-1:0]    row_data;
    logic [RW-1:0]    row_new;
    logic             upd_we;
    logic             mem_we;
    logic [RAW-1:0]   mem_wa;
    logic [RW-1:0]    mem_wd;

    assign idx_ext = EXT_W'(probe.idx);
    assign rd_row  = idx_ext[RAW+RB-1:RB];
    assign rd_bit  = idx_ext[RB-1:0];

    // A row read at the same edge as a write to it returns the old value; the write-back register forwards the new one.
    assign row_data = (wb_valid_reg && (wb_row_reg == s1_row_reg)) ? wb_data_reg : rdata_reg;
    assign row_new  = row_data | (RW'(1) << s1_bit_reg);
    assign upd_we   = s1_valid_reg && s1_set_reg;
    assign mem_we   = clr_busy_reg || upd_we;
    assign mem_wa   = clr_busy_reg ? clr_row_reg : s1_row_reg;
    assign mem_wd   = clr_busy_reg ? '0 : row_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (probe.valid)
            rdata_reg <= mem[rd_row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_row_reg == RAW'(ROWS - 1))
                    clr_busy_reg <= 1'b0;
                else
                    clr_row_reg <= clr_row_reg + 1'b1;
            end
            s1_valid_reg <= probe.valid;
            wb_valid_reg <= upd_we;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg  <= rd_row;
        s1_bit_reg  <= rd_bit;
        s1_set_reg  <= set_bits;
        wb_row_reg  <= s1_row_reg;
        wb_data_reg <= row_new;
    end

    assign result.valid = s1_valid_reg;
    assign result.hit   = row_data[s1_bit_reg];
    assign clearing     = clr_busy_reg;

endmodule

[verif/bloom_filter_insert_query_tb.sv]
// Self-checking testbench for the Bloom filter block: a directed table, then phases of
// random insert and query items under changing register settings, checked against a predictor.
// Depends on bfiq_pkg, the channel interfaces and the bloom_filter_insert_query top level.
module bloom_filter_insert_query_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        OUT_INSERTED = bfiq_pkg::OUT_INSERTED,
        OUT_FULL     = bfiq_pkg::OUT_REJECTED,
        OUT_ABSENT   = bfiq_pkg::OUT_ABSENT,
        OUT_MAYBE    = bfiq_pkg::OUT_PRESENT
    } outcome_e;

    typedef enum logic {
        FUNC_INSERT = bfiq_pkg::FUNC_INSERT,
        FUNC_QUERY  = bfiq_pkg::FUNC_QUERY
    } func_e;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_e;

    localparam logic [bfiq_pkg::ADDR_W-1:0] ADDR_USED_BITS  = 3'd0;
    localparam logic [bfiq_pkg::ADDR_W-1:0] ADDR_HASH_COUNT = 3'd4;

    localparam int FILTER_BITS = 4096;
    localparam int HASH_LIMIT  = 12;
    localparam int RANDOM_ITEMS = 1100;
    localparam int SETTLE_CYCLES = 40;

    localparam int SHIFT_A [12] = '{6, 5, 4, 13, 7, 11, 8, 21, 23, 30, 26, 31};
    localparam int SHIFT_B [12] = '{16, 7, 17, 14, 18, 20, 19, 15, 13, 2, 22, 5};

    typedef struct {
        outcome_e                      outcome;
        logic [bfiq_pkg::COUNT_W-1:0]  stored_count;
    } bloom_result_t;

    typedef struct {
        row_kind_e                     kind;
        func_e                         func;
        logic [bfiq_pkg::KEY_W-1:0]    key;
        logic [bfiq_pkg::SIZE_W-1:0]   used;
        logic [bfiq_pkg::HCNT_W-1:0]   hashes;
        bit                            fixed;
        outcome_e                      exp_outcome;
        logic [bfiq_pkg::COUNT_W-1:0]  exp_count;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bfiq_pkg::ADDR_W-1:0] paddr = '0;
    logic [bfiq_pkg::DATA_W-1:0] pwdata = '0;
    logic [bfiq_pkg::DATA_W-1:0] prdata;
    logic pready;

    bfiq_req_if req_ch ();
    bfiq_rsp_if rsp_ch ();

    bloom_filter_insert_query dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (req_ch),
        .out_ch  (rsp_ch)
    );

    always #4 clk = ~clk;

    bit                           filter_mem [FILTER_BITS];
    int unsigned                  keys_stored;
    logic [bfiq_pkg::SIZE_W-1:0]  cfg_used_bits;
    logic [bfiq_pkg::HCNT_W-1:0]  cfg_hash_count;

    bloom_result_t                pending_results [$];
    stim_row_t                    directed_rows [$];
    logic [bfiq_pkg::KEY_W-1:0]   inserted_keys [$];
    int                           mismatches = 0;
    bit                           calm = 1'b0;

    function automatic int unsigned probe_slot(int idx, logic [bfiq_pkg::KEY_W-1:0] key,
                                               int unsigned size);
        logic [63:0] k;
        logic [63:0] a;
        logic [63:0] s;
        k = {33'd0, key};
        a = (idx < 2) ? (k << SHIFT_A[idx]) : (k >> SHIFT_A[idx]);
        s = k + a + (k << SHIFT_B[idx]) + (k >> 1);
        return int'(s % 64'(size));
    endfunction

    function automatic bloom_result_t apply_to_filter(func_e f, logic [bfiq_pkg::KEY_W-1:0] key);
        bloom_result_t res;
        int unsigned   size;
        int unsigned   nh;
        size = (cfg_used_bits == 0) ? 1 : ((cfg_used_bits > FILTER_BITS) ? FILTER_BITS
                                                                           : cfg_used_bits);
        nh = (cfg_hash_count == 0) ? 1 : ((cfg_hash_count > HASH_LIMIT) ? HASH_LIMIT
                                                                          : cfg_hash_count);
        if (f == FUNC_INSERT) begin
            if (keys_stored > size / nh) begin
                res.outcome = OUT_FULL;
            end
            else begin
                for (int i = 0; i < nh; i++)
                begin
                    filter_mem[probe_slot(i, key, size)] = 1'b1;
                end
                keys_stored++;
                res.outcome = OUT_INSERTED;
            end
        end
        else begin
            res.outcome = OUT_MAYBE;
            for (int i = 0; i < nh; i++)
            begin
                if (!filter_mem[probe_slot(i, key, size)])
                begin
                    res.outcome = OUT_ABSENT;
                end
            end
        end
        res.stored_count = keys_stored[bfiq_pkg::COUNT_W-1:0];
        return res;
    endfunction

    function automatic void add_item(func_e f, logic [bfiq_pkg::KEY_W-1:0] key);
        stim_row_t row;
        row = '{ROW_ITEM, f, key, '0, '0, 1'b0, OUT_INSERTED, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_fixed(func_e f, logic [bfiq_pkg::KEY_W-1:0] key, outcome_e o,
                                      logic [bfiq_pkg::COUNT_W-1:0] c);
        stim_row_t row;
        row = '{ROW_ITEM, f, key, '0, '0, 1'b1, o, c};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [bfiq_pkg::SIZE_W-1:0] used,
                                    logic [bfiq_pkg::HCNT_W-1:0] hashes);
        stim_row_t row;
        row = '{ROW_CFG, FUNC_INSERT, '0, used, hashes, 1'b0, OUT_INSERTED, '0};
        directed_rows.push_back(row);
    endfunction

    task automatic reg_write(logic [bfiq_pkg::ADDR_W-1:0] addr, logic [bfiq_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic change_config(logic [bfiq_pkg::SIZE_W-1:0] used,
                                 logic [bfiq_pkg::HCNT_W-1:0] hashes);
        wait_idle();
        reg_write(ADDR_USED_BITS, {19'd0, used});
        cfg_used_bits = used;
        reg_write(ADDR_HASH_COUNT, {28'd0, hashes});
        cfg_hash_count = hashes;
    endtask

    task automatic send_item(func_e f, logic [bfiq_pkg::KEY_W-1:0] key, bit fixed,
                             outcome_e exp_o, logic [bfiq_pkg::COUNT_W-1:0] exp_c);
        int            gap;
        bloom_result_t res;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.key   <= key;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        res = apply_to_filter(f, key);
        if (fixed)
        begin
            res.outcome = exp_o;
            res.stored_count = exp_c;
        end
        pending_results.push_back(res);
        if (f == FUNC_INSERT)
        begin
            inserted_keys.push_back(key);
            if (inserted_keys.size() > 256)
            begin
                void'(inserted_keys.pop_front());
            end
        end
    endtask

    // Result side: random back-pressure, every accepted item checked in order.
    initial
    begin
        int            stall;
        bloom_result_t exp;
        rsp_ch.ready = 1'b0;
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_ch.valid);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item outcome=%0d stored_count=%0d", $time,
                         rsp_ch.outcome, rsp_ch.stored_count);
            end
            else begin
                exp = pending_results.pop_front();
                if (rsp_ch.outcome !== exp.outcome)
                begin
                    mismatches++;
                    $display("%0t: outcome expected %0d actual %0d", $time, exp.outcome,
                             rsp_ch.outcome);
                end
                if (rsp_ch.stored_count !== exp.stored_count)
                begin
                    mismatches++;
                    $display("%0t: stored_count expected %0d actual %0d", $time,
                             exp.stored_count, rsp_ch.stored_count);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int                          sent;
        int                          n;
        int                          pick;
        logic [bfiq_pkg::SIZE_W-1:0] used;
        logic [bfiq_pkg::HCNT_W-1:0] hashes;
        logic [bfiq_pkg::KEY_W-1:0]  key;
        func_e                       f;

        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_INSERT;
        req_ch.key   = '0;
        foreach (filter_mem[i])
        begin
            filter_mem[i] = 1'b0;
        end
        keys_stored    = 0;
        cfg_used_bits  = 13'd4096;
        cfg_hash_count = 4'd4;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Store is clear after reset; key zero hashes to slot zero everywhere.
        add_fixed(FUNC_QUERY, 31'd0, OUT_ABSENT, 13'd0);
        add_fixed(FUNC_QUERY, 31'h7FFF_FFFF, OUT_ABSENT, 13'd0);
        add_fixed(FUNC_INSERT, 31'd0, OUT_INSERTED, 13'd1);
        add_fixed(FUNC_QUERY, 31'd0, OUT_MAYBE, 13'd1);
        add_fixed(FUNC_INSERT, 31'h7FFF_FFFF, OUT_INSERTED, 13'd2);
        add_fixed(FUNC_QUERY, 31'h7FFF_FFFF, OUT_MAYBE, 13'd2);
        add_item(FUNC_QUERY, 31'h5555_5555);
        add_item(FUNC_QUERY, 31'h2AAA_AAAA);
        // A used size of zero acts as one, so every probe lands on slot zero.
        add_cfg(13'd0, 4'd4);
        add_fixed(FUNC_QUERY, 31'd12345, OUT_MAYBE, 13'd2);
        add_fixed(FUNC_INSERT, 31'd777, OUT_FULL, 13'd2);
        // Oversized used size and zero hash count.
        add_cfg(13'd8191, 4'd0);
        add_fixed(FUNC_INSERT, 31'h123_4567, OUT_INSERTED, 13'd3);
        add_fixed(FUNC_QUERY, 31'h123_4567, OUT_MAYBE, 13'd3);
        add_cfg(13'd8191, 4'd15);
        add_item(FUNC_QUERY, 31'h123_4567);
        add_fixed(FUNC_INSERT, 31'h0AB_CDEF, OUT_INSERTED, 13'd4);
        add_fixed(FUNC_QUERY, 31'h0AB_CDEF, OUT_MAYBE, 13'd4);
        add_cfg(13'd8, 4'd12);
        add_fixed(FUNC_INSERT, 31'd5, OUT_FULL, 13'd4);
        add_item(FUNC_QUERY, 31'd5);
        // Bits set under the old settings survive a register change.
        add_cfg(13'd4096, 4'd1);
        add_fixed(FUNC_QUERY, 31'h0AB_CDEF, OUT_MAYBE, 13'd4);
        add_cfg(13'd1, 4'd12);
        add_item(FUNC_QUERY, 31'd1);
        add_item(FUNC_INSERT, 31'd0);
        add_cfg(13'd4096, 4'd4);
        add_item(FUNC_QUERY, 31'h7FFF_FFFF);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                change_config(directed_rows[i].used, directed_rows[i].hashes);
            end
            else begin
                send_item(directed_rows[i].func, directed_rows[i].key, directed_rows[i].fixed,
                          directed_rows[i].exp_outcome, directed_rows[i].exp_count);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       used = 13'd0;
                1:       used = 13'($urandom_range(4097, 8191));
                2, 3, 4: used = 13'($urandom_range(1, 64));
                5:       used = 13'd4096;
                6:       used = 13'd1;
                default: used = 13'($urandom_range(1, 4096));
            endcase
            pick = $urandom_range(0, 5);
            hashes = (pick == 0) ? 4'd1 : ((pick == 1) ? 4'd12 : 4'($urandom_range(0, 15)));
            change_config(used, hashes);
            calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 100);
            for (int j = 0; j < n; j++)
            begin
                pick = $urandom_range(0, 9);
                key = 31'($urandom);
                f = FUNC_QUERY;
                if (pick < 4)
                begin
                    f = FUNC_INSERT;
                end
                else if (pick < 7)
                begin
                    if (inserted_keys.size() != 0)
                    begin
                        key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                    end
                end
                else if (pick == 9)
                begin
                    f = func_e'($urandom_range(0, 1));
                    case ($urandom_range(0, 2))
                        0:       key = 31'd0;
                        1:       key = 31'h7FFF_FFFF;
                        default: key = 31'd1 << $urandom_range(0, 30);
                    endcase
                end
                send_item(f, key, 1'b0, OUT_INSERTED, '0);
                sent++;
            end
        end

        calm = 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
